FILE: rtl/core/smr_pkg.sv
`default_nettype none

package smr_pkg;

    localparam int ROW_MAX = 64;
    localparam int IDX_W   = $clog2(ROW_MAX);
    localparam int CNT_W   = $clog2(ROW_MAX + 1);

    localparam int VAL_W   = 16;
    localparam int PROB_W  = 15;
    localparam int RES_W   = 16;
    localparam int Q_FRAC  = 15;

    // exponent value in Q1.15, 0 .. 32768
    localparam int E_W     = 16;
    localparam int SUM_W   = E_W + IDX_W;
    localparam int DOT_W   = VAL_W + PROB_W + IDX_W;
    localparam int DIFF_W  = DOT_W + 1;
    localparam int PROD_W  = DIFF_W + E_W + 1;
    localparam int LPROD_W = VAL_W + PROB_W + 1;

    // divider: numerator e * 2^15 + sum / 2, quotient at most 32768
    localparam int NUM_W   = E_W + Q_FRAC;
    localparam int QUO_W   = 16;
    localparam int DIV_BPC = 4;
    localparam int DIV_CYC = QUO_W / DIV_BPC;
    localparam int DIVC_W  = $clog2(DIV_CYC);

    // exponent lookup: t = max - value, exp(-t/256) = int part * frac part
    localparam int T_W      = VAL_W + 1;
    localparam int T_FRAC_W = 8;
    localparam int T_INT_W  = 4;
    localparam int T_LIMIT  = 2700;
    localparam int TAB_W    = 32;
    localparam int EPROD_W  = 2 * TAB_W;
    localparam int E_SHIFT  = 47;
    localparam int B_SHIFT  = 30;

    localparam int RES_MAXP = 32767;
    localparam int RES_MINN = -32768;

    localparam logic CMD_FWD = 1'b0;
    localparam logic CMD_BWD = 1'b1;

    typedef logic [(1 << T_FRAC_W)-1:0][TAB_W-1:0] t_frac_tab;
    typedef logic [(1 << T_INT_W)-1:0][TAB_W-1:0]  t_int_tab;

    typedef struct packed {
        logic             load;
        logic             first;
        logic             clear;
        logic             exp_ld;
        logic             exp_mul;
        logic             exp_wr;
        logic             div_go;
        logic             bdiff;
        logic             bmul;
        logic             emit;
        logic             sel_bwd;
        logic             last;
        logic [IDX_W-1:0] addr;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_sts;

    // exp(-2^-16) in Q.62
    localparam logic [63:0] EXP_STEP_Q62 = 64'h3FFF_C000_1FFF_F555;

    function automatic logic [63:0] f_mulq62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << 61);
        return p[125:62];
    endfunction

    // exp(-t/256) in Q.62, built at elaboration only
    function automatic logic [63:0] f_exp_q62(input int t);
        logic [63:0] e1;
        logic [63:0] pw;
        logic [63:0] res;
        e1 = EXP_STEP_Q62;
        for (int k = 0; k < 8; k++) begin
            e1 = f_mulq62(e1, e1);
        end
        res = 64'd1 << 62;
        pw  = e1;
        for (int k = 0; k < 12; k++) begin
            if (((t >> k) & 1) != 0) begin
                res = f_mulq62(res, pw);
            end
            pw = f_mulq62(pw, pw);
        end
        return res;
    endfunction

    function automatic logic [TAB_W-1:0] f_q31(input int t);
        logic [63:0] r;
        r = f_exp_q62(t) + (64'd1 << 30);
        return r[62:31];
    endfunction

    function automatic t_frac_tab f_frac_tab();
        t_frac_tab tab;
        for (int i = 0; i < (1 << T_FRAC_W); i++) begin
            tab[i] = f_q31(i);
        end
        return tab;
    endfunction

    function automatic t_int_tab f_int_tab();
        t_int_tab tab;
        for (int i = 0; i < (1 << T_INT_W); i++) begin
            tab[i] = f_q31(i << T_FRAC_W);
        end
        return tab;
    endfunction

    localparam t_frac_tab EXP_FRAC = f_frac_tab();
    localparam t_int_tab  EXP_INT  = f_int_tab();

endpackage

`default_nettype wire

FILE: rtl/core/smr_in_if.sv
`default_nettype none

interface smr_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [smr_pkg::VAL_W-1:0]    value;
    logic        [smr_pkg::PROB_W-1:0]   prob;
    logic                                last_in;

    modport source (output valid, command, value, prob, last_in, input ready);
    modport sink   (input valid, command, value, prob, last_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/smr_out_if.sv
`default_nettype none

interface smr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [smr_pkg::RES_W-1:0] result;
    logic                             last_out;

    modport source (output valid, result, last_out, input ready);
    modport sink   (input valid, result, last_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/smr_ram.sv
`default_nettype none

module smr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

FILE: rtl/core/smr_div.sv
`default_nettype none

// restoring divider, DIV_BPC quotient bits per cycle
module smr_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [smr_pkg::NUM_W-1:0]   i_num,
    input  wire logic [smr_pkg::SUM_W-1:0]   i_den,
    output      logic                        o_done,
    output      logic [smr_pkg::QUO_W-1:0]   o_quo
);
    logic [smr_pkg::SUM_W-1:0]  r_rem, n_rem;
    logic [smr_pkg::QUO_W-1:0]  r_quo, n_quo;
    logic [smr_pkg::SUM_W-1:0]  r_den;
    logic [smr_pkg::DIVC_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [smr_pkg::SUM_W:0]    w_trial;

    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        w_trial = '0;
        for (int k = 0; k < smr_pkg::DIV_BPC; k++) begin
            w_trial = {n_rem, n_quo[smr_pkg::QUO_W-1]};
            n_quo   = {n_quo[smr_pkg::QUO_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                w_trial  = w_trial - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = w_trial[smr_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == smr_pkg::DIVC_W'(smr_pkg::DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= smr_pkg::SUM_W'(i_num[smr_pkg::NUM_W-1:smr_pkg::QUO_W]);
            r_quo <= i_num[smr_pkg::QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
`endif
endmodule

`default_nettype wire

FILE: rtl/core/smr_dp.sv
`default_nettype none

module smr_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire smr_pkg::t_dp_cmd                  i_cmd,
    output      smr_pkg::t_dp_sts                  o_sts,
    input  wire logic signed [smr_pkg::VAL_W-1:0]  i_value,
    input  wire logic        [smr_pkg::PROB_W-1:0] i_prob,
    output      logic                              o_res_valid,
    input  wire logic                              i_res_ready,
    output      logic signed [smr_pkg::RES_W-1:0]  o_result,
    output      logic                              o_last
);
    logic signed [smr_pkg::VAL_W-1:0]   w_rv;
    logic        [smr_pkg::E_W-1:0]     w_rp;
    logic        [smr_pkg::E_W-1:0]     w_pwdata;
    logic                               w_pwe;

    logic signed [smr_pkg::VAL_W-1:0]   r_max;
    logic signed [smr_pkg::DOT_W-1:0]   r_dot;
    logic signed [smr_pkg::LPROD_W-1:0] w_lprod;
    logic        [smr_pkg::SUM_W-1:0]   r_sum;

    logic        [smr_pkg::T_W-1:0]     w_t;
    logic        [smr_pkg::TAB_W-1:0]   r_ta, r_tb;
    logic                               r_zero;
    logic        [smr_pkg::EPROD_W-1:0] r_eprod;
    logic        [smr_pkg::EPROD_W-1:0] w_eround;
    logic        [smr_pkg::E_W-1:0]     w_e;

    logic        [smr_pkg::NUM_W-1:0]   w_num;
    logic                               w_div_done;
    logic        [smr_pkg::QUO_W-1:0]   w_quo;

    logic signed [smr_pkg::DIFF_W-1:0]  r_diff;
    logic        [smr_pkg::E_W-1:0]     r_bp;
    logic signed [smr_pkg::PROD_W-1:0]  r_bprod;
    logic signed [smr_pkg::PROD_W-1:0]  w_bsh;

    logic signed [smr_pkg::RES_W-1:0]   w_fres, w_bres;
    logic                               r_ov;
    logic signed [smr_pkg::RES_W-1:0]   r_res;
    logic                               r_last;

    assign w_pwe    = i_cmd.load | i_cmd.exp_wr;
    assign w_pwdata = i_cmd.load ? {1'b0, i_prob} : w_e;

    smr_ram #(.WIDTH(smr_pkg::VAL_W), .DEPTH(smr_pkg::ROW_MAX)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_value),
        .i_raddr (i_cmd.addr),
        .o_rdata (w_rv)
    );

    smr_ram #(.WIDTH(smr_pkg::E_W), .DEPTH(smr_pkg::ROW_MAX)) u_prob_ram (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (i_cmd.addr),
        .i_wdata (w_pwdata),
        .i_raddr (i_cmd.addr),
        .o_rdata (w_rp)
    );

    // load: running max and gradient dot product
    assign w_lprod = i_value * $signed({1'b0, i_prob});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_cmd.first || (i_value > r_max)) begin
                r_max <= i_value;
            end
            r_dot <= (i_cmd.first ? smr_pkg::DOT_W'(0) : r_dot)
                     + smr_pkg::DOT_W'(w_lprod);
        end
    end

    // exponent pass
    assign w_t      = {r_max[smr_pkg::VAL_W-1], r_max} - {w_rv[smr_pkg::VAL_W-1], w_rv};
    assign w_eround = r_eprod + (smr_pkg::EPROD_W'(1) << (smr_pkg::E_SHIFT - 1));
    assign w_e      = (r_zero || (r_eprod[smr_pkg::EPROD_W-1:smr_pkg::E_SHIFT] == '0)) ? '0
                    : w_eround[smr_pkg::E_SHIFT+smr_pkg::E_W-1:smr_pkg::E_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_ld) begin
            r_zero <= (w_t > smr_pkg::T_W'(smr_pkg::T_LIMIT));
            r_ta   <= smr_pkg::EXP_INT[w_t[smr_pkg::T_FRAC_W+smr_pkg::T_INT_W-1:smr_pkg::T_FRAC_W]];
            r_tb   <= smr_pkg::EXP_FRAC[w_t[smr_pkg::T_FRAC_W-1:0]];
        end
        if (i_cmd.exp_mul) begin
            r_eprod <= r_ta * r_tb;
        end
        if (i_cmd.clear) begin
            r_sum <= '0;
        end else if (i_cmd.exp_wr) begin
            r_sum <= r_sum + smr_pkg::SUM_W'(w_e);
        end
    end

    // normalize pass
    assign w_num = smr_pkg::NUM_W'({w_rp, smr_pkg::Q_FRAC'(0)})
                 + smr_pkg::NUM_W'(r_sum[smr_pkg::SUM_W-1:1]);

    smr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (w_num),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_fres = (w_quo > smr_pkg::QUO_W'(smr_pkg::RES_MAXP))
                  ? smr_pkg::RES_W'(smr_pkg::RES_MAXP) : $signed(w_quo);

    // gradient pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.bdiff) begin
            r_diff <= (smr_pkg::DIFF_W'(w_rv) <<< smr_pkg::Q_FRAC) - smr_pkg::DIFF_W'(r_dot);
            r_bp   <= w_rp;
        end
        if (i_cmd.bmul) begin
            r_bprod <= r_diff * $signed({1'b0, r_bp});
        end
    end

    assign w_bsh = (r_bprod + (smr_pkg::PROD_W'(1) <<< (smr_pkg::B_SHIFT - 1)))
                   >>> smr_pkg::B_SHIFT;

    always_comb begin
        if (w_bsh > smr_pkg::PROD_W'(smr_pkg::RES_MAXP)) begin
            w_bres = smr_pkg::RES_W'(smr_pkg::RES_MAXP);
        end else if (w_bsh < smr_pkg::PROD_W'(smr_pkg::RES_MINN)) begin
            w_bres = smr_pkg::RES_W'(smr_pkg::RES_MINN);
        end else begin
            w_bres = w_bsh[smr_pkg::RES_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res  <= i_cmd.sel_bwd ? w_bres : w_fres;
            r_last <= i_cmd.last;
        end
    end

    assign o_res_valid    = r_ov;
    assign o_result       = r_res;
    assign o_last         = r_last;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_ov || i_res_ready;
endmodule

`default_nettype wire

FILE: rtl/core/smr_ctrl.sv
`default_nettype none

module smr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_command,
    input  wire logic             i_in_last,
    output      logic             o_in_ready,
    output      smr_pkg::t_dp_cmd o_cmd,
    input  wire smr_pkg::t_dp_sts i_sts
);
    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_CLOSE  = 4'd1;
    localparam logic [3:0] S_F_RD   = 4'd2;
    localparam logic [3:0] S_F_T    = 4'd3;
    localparam logic [3:0] S_F_MUL  = 4'd4;
    localparam logic [3:0] S_F_WR   = 4'd5;
    localparam logic [3:0] S_D_RD   = 4'd6;
    localparam logic [3:0] S_D_GO   = 4'd7;
    localparam logic [3:0] S_D_WAIT = 4'd8;
    localparam logic [3:0] S_D_EMIT = 4'd9;
    localparam logic [3:0] S_B_RD   = 4'd10;
    localparam logic [3:0] S_B_DIFF = 4'd11;
    localparam logic [3:0] S_B_MUL  = 4'd12;
    localparam logic [3:0] S_B_EMIT = 4'd13;

    logic [3:0]                r_state, n_state;
    logic [smr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [smr_pkg::CNT_W-1:0] r_n, n_n;
    logic [smr_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_mode, n_mode;
    logic                      w_acc;
    logic                      w_last_idx;

    assign w_acc      = i_in_valid && (r_state == S_LOAD);
    assign w_last_idx = ({1'b0, r_idx} == (r_n - smr_pkg::CNT_W'(1)));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_idx   = r_idx;
        n_mode  = r_mode;
        o_cmd   = '0;
        o_cmd.addr    = (r_state == S_LOAD) ? r_cnt[smr_pkg::IDX_W-1:0] : r_idx;
        o_cmd.sel_bwd = (r_mode == smr_pkg::CMD_BWD);
        o_cmd.last    = w_last_idx;
        case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.first = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_mode = i_in_command;
                    end
                    n_cnt = r_cnt + 1'b1;
                    if (i_in_last || (r_cnt == smr_pkg::CNT_W'(smr_pkg::ROW_MAX - 1))) begin
                        n_n     = r_cnt + 1'b1;
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                o_cmd.clear = 1'b1;
                n_idx       = '0;
                n_state     = (r_mode == smr_pkg::CMD_BWD) ? S_B_RD : S_F_RD;
            end
            S_F_RD: n_state = S_F_T;
            S_F_T: begin
                o_cmd.exp_ld = 1'b1;
                n_state      = S_F_MUL;
            end
            S_F_MUL: begin
                o_cmd.exp_mul = 1'b1;
                n_state       = S_F_WR;
            end
            S_F_WR: begin
                o_cmd.exp_wr = 1'b1;
                if (w_last_idx) begin
                    n_idx   = '0;
                    n_state = S_D_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_F_RD;
                end
            end
            S_D_RD: n_state = S_D_GO;
            S_D_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_D_WAIT;
            end
            S_D_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_D_EMIT;
                end
            end
            S_D_EMIT, S_B_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (w_last_idx) begin
                        n_cnt   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = (r_state == S_D_EMIT) ? S_D_RD : S_B_RD;
                    end
                end
            end
            S_B_RD: n_state = S_B_DIFF;
            S_B_DIFF: begin
                o_cmd.bdiff = 1'b1;
                n_state     = S_B_MUL;
            end
            S_B_MUL: begin
                o_cmd.bmul = 1'b1;
                n_state    = S_B_EMIT;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_n     <= '0;
            r_idx   <= '0;
            r_mode  <= smr_pkg::CMD_FWD;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_idx   <= n_idx;
            r_mode  <= n_mode;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);

`ifndef SYNTHESIS
    a_cnt_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_cnt < smr_pkg::CNT_W'(smr_pkg::ROW_MAX)))
        else $error("row count past capacity while loading");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free) else $error("result emitted over a held one");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD && r_state != S_CLOSE) |-> ({1'b0, r_idx} < r_n))
        else $error("element index beyond row length");
`endif
endmodule

`default_nettype wire

FILE: rtl/core/softmax_row_forward_backward_unit.sv
`default_nettype none

// Softmax row unit, forward and backward.
// Input channel i_item: one row element per item (command, value, prob,
// last_in). The first item of a row picks the mode; last_in closes the row,
// and so does the item that fills the 64th entry.
// Items are taken one per cycle while a row loads; ready drops once the row
// closes and rises again once its final result enters the output register.
// Output channel o_res: one result per element, in element order, last_out
// on the final one. A single output register holds each result.
// Forward: after the close step, an exp and sum step per element (RAM read,
// table lookup, 32x32 multiply, round), then a normalize step per element
// (RAM read, radix-16 divider, emit).
// Backward: after the close step, per element: RAM read, difference,
// multiply, round and saturate, emit.
// A stalled receiver holds the sequencer in its emit step; nothing is lost.
// Reset (synchronous, active low) empties the open row and the output
// register; the row RAMs are not cleared, only written entries are read.
module softmax_row_forward_backward_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    smr_in_if.sink     i_item,
    smr_out_if.source  o_res
);
    smr_pkg::t_dp_cmd w_cmd;
    smr_pkg::t_dp_sts w_sts;

    // sequencer: load, exponent, normalize or gradient passes
    smr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_item.valid),
        .i_in_command (i_item.command),
        .i_in_last    (i_item.last_in),
        .o_in_ready   (i_item.ready),
        .o_cmd        (w_cmd),
        .i_sts        (w_sts)
    );

    // arithmetic, row RAMs, divider and output register
    smr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_value     (i_item.value),
        .i_prob      (i_item.prob),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_result    (o_res.result),
        .o_last      (o_res.last_out)
    );
endmodule

`default_nettype wire

FILE: verif/tb_softmax_row_forward_backward_unit.sv
`default_nettype none

module tb_softmax_row_forward_backward_unit;
    import smr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1200;

    typedef struct {
        logic signed [RES_W-1:0] result;
        logic                    last_out;
    } t_expected_result;

    logic i_clk;
    logic i_rst_n;

    smr_in_if  item_ch();
    smr_out_if res_ch();

    softmax_row_forward_backward_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // model state of the open row
    logic signed [VAL_W-1:0]  row_vals[$];
    logic        [PROB_W-1:0] row_prbs[$];
    logic                     row_is_bwd;

    t_expected_result pending_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int quiet_cycles;
    int fwd_rows;
    int bwd_rows;
    int results_seen;
    int items_sent;

    // floor(a * b / 2^62), operands at most 1.0 in Q.62
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // exp(-t/256) in Q1.15, rounded half up, flushed to zero below 2^-15
    function automatic logic [31:0] exp_q15(input logic [31:0] t);
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] y;
        if (t > 32'd2700) return 32'd0;
        y    = {32'd0, t} << 46;
        term = 64'd1 << 62;
        acc  = 64'd1 << 62;
        for (int k = 1; k <= 12; k++) begin
            term = mul_q62(term, y) / k;
            if (k & 1) acc = acc - term;
            else acc = acc + term;
        end
        for (int k = 0; k < 8; k++) acc = mul_q62(acc, acc);
        if ((acc >> 47) == 0) return 32'd0;
        return 32'((acc + (64'd1 << 46)) >> 47);
    endfunction

    task automatic softmax_row_expect();
        longint   row_peak;
        longint   exp_sum;
        longint   quo;
        longint   exps[$];
        t_expected_result r;
        row_peak = row_vals[0];
        foreach (row_vals[i]) if (row_vals[i] > row_peak) row_peak = row_vals[i];
        exp_sum = 0;
        foreach (row_vals[i]) begin
            exps.push_back(exp_q15(32'(row_peak - row_vals[i])));
            exp_sum += exps[i];
        end
        foreach (exps[i]) begin
            quo = (exps[i] * 32768 + exp_sum / 2) / exp_sum;
            if (quo > RES_MAXP) quo = RES_MAXP;
            r.result   = RES_W'(quo);
            r.last_out = (i == exps.size() - 1);
            pending_results.push_back(r);
        end
        fwd_rows++;
    endtask

    task automatic grad_row_expect();
        longint dot;
        longint diff;
        longint g;
        t_expected_result r;
        dot = 0;
        foreach (row_vals[i]) dot += longint'(row_vals[i]) * longint'(row_prbs[i]);
        foreach (row_vals[i]) begin
            diff = longint'(row_vals[i]) * 32768 - dot;
            // round half up, then floor
            g = (diff * longint'(row_prbs[i]) + (64'sd1 <<< 29)) >>> 30;
            if (g > RES_MAXP) g = RES_MAXP;
            if (g < RES_MINN) g = RES_MINN;
            r.result   = RES_W'(g);
            r.last_out = (i == row_vals.size() - 1);
            pending_results.push_back(r);
        end
        bwd_rows++;
    endtask

    // Hand one item to the block; update the row model on acceptance.
    task automatic send_item(input logic cmd, input logic signed [VAL_W-1:0] val,
                             input logic [PROB_W-1:0] prb, input logic lst);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.command <= cmd;
        item_ch.value   <= val;
        item_ch.prob    <= prb;
        item_ch.last_in <= lst;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
        if (row_vals.size() == 0) row_is_bwd = (cmd == CMD_BWD);
        row_vals.push_back(val);
        row_prbs.push_back(prb);
        if (lst || row_vals.size() == ROW_MAX) begin
            if (row_is_bwd) grad_row_expect();
            else softmax_row_expect();
            row_vals.delete();
            row_prbs.delete();
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
    endtask

    // Send a row of n elements; last_in only when closed is set.
    task automatic send_row(input logic cmd, input int n, input logic signed [VAL_W-1:0] base,
                            input int spread, input logic closed);
        logic signed [VAL_W-1:0] v;
        for (int i = 0; i < n; i++) begin
            if (spread == 0) v = VAL_W'($urandom);
            else v = base + VAL_W'($urandom_range(spread, 0)) - VAL_W'(spread / 2);
            // noise on command mid-row must be ignored
            send_item((i == 0) ? cmd : logic'($urandom_range(1, 0)), v,
                      PROB_W'($urandom), closed && (i == n - 1));
        end
    endtask

    // drop valid so the last item is not taken twice, then drain
    task automatic wait_idle();
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver: stall at random on each falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_expected_result e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result %0d", res_ch.result);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (res_ch.result !== e.result) begin
                    $error("result: expected %0d, got %0d", e.result, res_ch.result);
                    error_count++;
                end
                if (res_ch.last_out !== e.last_out) begin
                    $error("last_out: expected %0b, got %0b", e.last_out, res_ch.last_out);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("tb_softmax_row_forward_backward_unit: errors");
            $finish;
        end
    end

    // extremes of the forward path, single-element rows, flush to zero
    task automatic test_forward_directed();
        send_item(CMD_FWD, 16'sh7FFF, 15'h7FFF, 1'b1);
        send_item(CMD_FWD, -16'sd32768, 15'h0000, 1'b0);
        send_item(CMD_FWD, 16'sh7FFF, 15'h5555, 1'b0);
        send_item(CMD_FWD, 16'sh7FFF, 15'h2AAA, 1'b1);
        send_item(CMD_FWD, 16'sd0, 15'h0, 1'b0);
        send_item(CMD_FWD, -16'sd2700, 15'h0, 1'b0);
        send_item(CMD_FWD, -16'sd2701, 15'h0, 1'b0);
        send_item(CMD_FWD, -16'sd256, 15'h0, 1'b1);
        send_item(CMD_FWD, 16'sd5, 15'h0, 1'b0);
        send_item(CMD_FWD, 16'sd5, 15'h0, 1'b1);
        wait_idle();
    endtask

    // extremes of the backward path, saturation both ways, mode held mid-row
    task automatic test_backward_directed();
        send_item(CMD_BWD, 16'sh7FFF, 15'h7FFF, 1'b0);
        send_item(CMD_FWD, -16'sd32768, 15'h7FFF, 1'b1);
        send_item(CMD_BWD, -16'sd32768, 15'h7FFF, 1'b0);
        send_item(CMD_BWD, 16'sh7FFF, 15'h0001, 1'b1);
        send_item(CMD_BWD, 16'sd256, 15'h4000, 1'b0);
        send_item(CMD_FWD, -16'sd256, 15'h4000, 1'b1);
        send_item(CMD_BWD, 16'sh5A5A, 15'h2A5A, 1'b1);
        send_item(CMD_FWD, 16'sd100, 15'h7FFF, 1'b0);
        send_item(CMD_BWD, 16'sd200, 15'h0, 1'b1);
        wait_idle();
    endtask

    // random rows, mostly short, with the odd full row closed by count
    task automatic test_random_rows(input int item_goal);
        int start;
        int n;
        logic cmd;
        start = items_sent;
        while (items_sent - start < item_goal) begin
            cmd = logic'($urandom_range(1, 0));
            if ($urandom_range(19, 0) == 0) begin
                send_row(cmd, ROW_MAX, VAL_W'($urandom), $urandom_range(3000, 0),
                         logic'($urandom_range(1, 0)));
            end else begin
                n = $urandom_range(8, 1);
                case ($urandom_range(3, 0))
                    0: send_row(cmd, n, 16'sd0, 0, 1'b1);
                    1: send_row(cmd, n, VAL_W'($urandom), 600, 1'b1);
                    default: send_row(cmd, n, VAL_W'($urandom), $urandom_range(4000, 2), 1'b1);
                endcase
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.command = CMD_FWD;
        item_ch.value   = '0;
        item_ch.prob    = '0;
        item_ch.last_in = 1'b0;
        res_ch.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        error_count     = 0;
        quiet_cycles    = 0;
        fwd_rows        = 0;
        bwd_rows        = 0;
        results_seen    = 0;
        items_sent      = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_forward_directed();
        test_backward_directed();

        // idle phases: none, sender only, receiver only, both
        test_random_rows(100);
        send_idle_pct = 61;
        test_random_rows(100);
        send_idle_pct  = 0;
        recv_stall_pct = 61;
        test_random_rows(100);
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        test_random_rows(100);
        release_input();

        for (int i = 0; i < DRAIN_CYCLES && pending_results.size() != 0; i++)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end

        $display("covered %0d items: %0d forward and %0d backward rows, %0d results checked",
                 items_sent, fwd_rows, bwd_rows, results_seen);
        if (error_count == 0)
            $display("tb_softmax_row_forward_backward_unit: clean");
        else
            $display("tb_softmax_row_forward_backward_unit: errors");
        $finish;
    end

endmodule

`default_nettype wire
